// File: src/brc_pkg.sv
// brc_pkg: shared types and constants for the blit rectangle clipper
// holds the command, settings and result structs; depends on nothing

package brc_pkg;

    // width of the internal signed coordinate arithmetic, covers MAX_DIM up to 4096
    localparam int unsigned CW = 16;

    // field widths fixed by the command and result formats
    localparam int unsigned IN_W  = 12;
    localparam int unsigned REG_W = 11;
    localparam int unsigned POS_W = 10;
    localparam int unsigned LEN_W = 11;
    localparam int unsigned IDX_W = 3;

    // register indexes of the configuration port
    typedef enum logic [IDX_W-1:0] {
        IDX_CLIP_LEFT     = 3'd0,
        IDX_CLIP_TOP      = 3'd1,
        IDX_CLIP_WIDTH    = 3'd2,
        IDX_CLIP_HEIGHT   = 3'd3,
        IDX_SOURCE_WIDTH  = 3'd4,
        IDX_SOURCE_HEIGHT = 3'd5
    } reg_idx_t;

    typedef logic signed [CW-1:0] coord_t;

    // one blit command as captured at the input register
    typedef struct packed {
        logic                    whole_source;
        logic signed [IN_W-1:0]  rect_x;
        logic signed [IN_W-1:0]  rect_y;
        logic signed [IN_W-1:0]  rect_w;
        logic signed [IN_W-1:0]  rect_h;
        logic signed [IN_W-1:0]  dest_x;
        logic signed [IN_W-1:0]  dest_y;
    } cmd_t;

    // saturated surface and clip bounds handed from the register file to the core
    typedef struct packed {
        coord_t src_w;
        coord_t src_h;
        coord_t clip_l;
        coord_t clip_t;
        coord_t clip_r;
        coord_t clip_b;
    } bounds_t;

    // one clipped copy rectangle
    typedef struct packed {
        logic             ok;
        logic [POS_W-1:0] src_x;
        logic [POS_W-1:0] src_y;
        logic [POS_W-1:0] dst_x;
        logic [POS_W-1:0] dst_y;
        logic [LEN_W-1:0] width;
        logic [LEN_W-1:0] height;
    } rect_t;

endpackage

// File: src/brc_cfg_regs.sv
// brc_cfg_regs: clip and source surface registers with their saturation
// depends on brc_pkg for the register indexes and the bounds struct

module brc_cfg_regs
    import brc_pkg::*;
#(
    parameter int MAX_DIM = 1024
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_index,
    input  logic [REG_W-1:0] wr_data,
    output bounds_t          bounds
);

    localparam coord_t MAX_C = CW'(MAX_DIM);

    logic [REG_W-1:0] clip_left_reg;
    logic [REG_W-1:0] clip_top_reg;
    logic [REG_W-1:0] clip_width_reg;
    logic [REG_W-1:0] clip_height_reg;
    logic [REG_W-1:0] source_width_reg;
    logic [REG_W-1:0] source_height_reg;

    coord_t clip_r_sum;
    coord_t clip_b_sum;

    function automatic coord_t sat_dim(input logic [REG_W-1:0] v);
        coord_t x;
        x = coord_t'({{(CW-REG_W){1'b0}}, v});
        return (x > MAX_C) ? MAX_C : x;
    endfunction

    // register writes, unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_left_reg     <= REG_W'(0);
            clip_top_reg      <= REG_W'(0);
            clip_width_reg    <= REG_W'(1024);
            clip_height_reg   <= REG_W'(1024);
            source_width_reg  <= REG_W'(1024);
            source_height_reg <= REG_W'(1024);
        end
        else if (wr_en)
        begin
            case (wr_index)
                IDX_CLIP_LEFT:     clip_left_reg     <= wr_data;
                IDX_CLIP_TOP:      clip_top_reg      <= wr_data;
                IDX_CLIP_WIDTH:    clip_width_reg    <= wr_data;
                IDX_CLIP_HEIGHT:   clip_height_reg   <= wr_data;
                IDX_SOURCE_WIDTH:  source_width_reg  <= wr_data;
                IDX_SOURCE_HEIGHT: source_height_reg <= wr_data;
                default:           ;
            endcase
        end
    end

    // source size saturated, clip edges limited to the destination surface
    always_comb
    begin
        bounds.src_w  = sat_dim(source_width_reg);
        bounds.src_h  = sat_dim(source_height_reg);
        bounds.clip_l = sat_dim(clip_left_reg);
        bounds.clip_t = sat_dim(clip_top_reg);
        clip_r_sum    = bounds.clip_l + coord_t'({{(CW-REG_W){1'b0}}, clip_width_reg});
        clip_b_sum    = bounds.clip_t + coord_t'({{(CW-REG_W){1'b0}}, clip_height_reg});
        bounds.clip_r = (clip_r_sum > MAX_C) ? MAX_C : clip_r_sum;
        bounds.clip_b = (clip_b_sum > MAX_C) ? MAX_C : clip_b_sum;
    end

endmodule

// File: src/brc_clip_core.sv
// brc_clip_core: single pass clipping of one command against source and clip bounds
// depends on brc_pkg for the command, bounds and result structs

module brc_clip_core
    import brc_pkg::*;
(
    input  cmd_t    cmd,
    input  bounds_t bounds,
    output rect_t   rect
);

    typedef struct packed {
        coord_t org;
        coord_t dst;
        coord_t len;
        logic   empty_src;
        logic   empty_dst;
    } axis_t;

    axis_t ax_x;
    axis_t ax_y;

    function automatic coord_t sext(input logic signed [IN_W-1:0] v);
        return coord_t'(v);
    endfunction

    // trim one axis to the source extent, then to the clip span
    function automatic axis_t clip_axis(input coord_t org_in, input coord_t len_in,
                                        input coord_t dst_in, input coord_t src_ext,
                                        input coord_t lo, input coord_t hi);
        axis_t  a;
        coord_t org;
        coord_t len;
        coord_t dst;
        coord_t far;
        org = org_in;
        len = len_in;
        dst = dst_in;
        // negative source origin pushes the destination along
        if (org < 0)
        begin
            len = len + org;
            dst = dst - org;
            org = '0;
        end
        if (org + len > src_ext)
            len = src_ext - org;
        a.empty_src = (len <= 0);
        // clip span, left or top cuts move the source origin
        far = dst + len;
        if (dst < lo)
        begin
            org = org + (lo - dst);
            len = len - (lo - dst);
            dst = lo;
        end
        if (far > hi)
            len = len - (far - hi);
        a.empty_dst = (len <= 0);
        a.org = org;
        a.dst = dst;
        a.len = len;
        return a;
    endfunction

    // both axes side by side
    always_comb
    begin
        if (cmd.whole_source)
        begin
            ax_x = clip_axis('0, bounds.src_w, sext(cmd.dest_x), bounds.src_w,
                             bounds.clip_l, bounds.clip_r);
            ax_y = clip_axis('0, bounds.src_h, sext(cmd.dest_y), bounds.src_h,
                             bounds.clip_t, bounds.clip_b);
        end
        else
        begin
            ax_x = clip_axis(sext(cmd.rect_x), sext(cmd.rect_w), sext(cmd.dest_x),
                             bounds.src_w, bounds.clip_l, bounds.clip_r);
            ax_y = clip_axis(sext(cmd.rect_y), sext(cmd.rect_h), sext(cmd.dest_y),
                             bounds.src_h, bounds.clip_t, bounds.clip_b);
        end
    end

    // empty rectangle gives an all zero result
    always_comb
    begin
        rect = '0;
        if (!(ax_x.empty_src || ax_y.empty_src || ax_x.empty_dst || ax_y.empty_dst))
        begin
            rect.ok     = 1'b1;
            rect.src_x  = ax_x.org[POS_W-1:0];
            rect.src_y  = ax_y.org[POS_W-1:0];
            rect.dst_x  = ax_x.dst[POS_W-1:0];
            rect.dst_y  = ax_y.dst[POS_W-1:0];
            rect.width  = ax_x.len[LEN_W-1:0];
            rect.height = ax_y.len[LEN_W-1:0];
        end
    end

endmodule

// File: src/blit_rectangle_clipper.sv
// blit_rectangle_clipper: top level, input register, clipping core and result register
// depends on brc_pkg, brc_cfg_regs and brc_clip_core
//
// usage
//   commands: a request is taken at a rising edge with start high and busy low.
//   busy is held low, so a new command may be issued in every cycle.
//   configuration: cfg_valid with cfg_index and cfg_data writes one register;
//   cfg_ready is always high. write only while no command is in flight.
//   results: done pulses for one cycle with valid_res and the clipped rectangle.
//   a taken command is held in the input register, clipped, and captured in the
//   result register, which drives done; one result per cycle is sustained.
//   the single clipping pass sits between these two registers.
//   the receiver cannot stall: done marks each result for exactly one cycle.
//   reset clears the pipeline valid flags and loads clip 0,0,1024,1024 and a
//   1024 by 1024 source surface.

module blit_rectangle_clipper
    import brc_pkg::*;
#(
    parameter int MAX_DIM = 1024
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    // command request
    input  logic                    start,
    output logic                    busy,
    input  logic                    whole_source,
    input  logic signed [IN_W-1:0]  rect_x,
    input  logic signed [IN_W-1:0]  rect_y,
    input  logic signed [IN_W-1:0]  rect_w,
    input  logic signed [IN_W-1:0]  rect_h,
    input  logic signed [IN_W-1:0]  dest_x,
    input  logic signed [IN_W-1:0]  dest_y,
    // configuration writes
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [IDX_W-1:0]        cfg_index,
    input  logic [REG_W-1:0]        cfg_data,
    // result
    output logic                    done,
    output logic                    valid_res,
    output logic [POS_W-1:0]        out_src_x,
    output logic [POS_W-1:0]        out_src_y,
    output logic [POS_W-1:0]        out_dest_x,
    output logic [POS_W-1:0]        out_dest_y,
    output logic [LEN_W-1:0]        out_width,
    output logic [LEN_W-1:0]        out_height
);

    logic    cmd_valid_reg;
    cmd_t    cmd_reg;
    logic    done_reg;
    rect_t   rect_reg;
    rect_t   rect_next;
    bounds_t bounds;
    logic    accept;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    // configuration registers
    brc_cfg_regs #(
        .MAX_DIM (MAX_DIM)
    ) u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .bounds   (bounds)
    );

    // input register valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cmd_valid_reg <= 1'b0;
        else
            cmd_valid_reg <= accept;
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg.whole_source <= whole_source;
            cmd_reg.rect_x       <= rect_x;
            cmd_reg.rect_y       <= rect_y;
            cmd_reg.rect_w       <= rect_w;
            cmd_reg.rect_h       <= rect_h;
            cmd_reg.dest_x       <= dest_x;
            cmd_reg.dest_y       <= dest_y;
        end
    end

    // clipping pass
    brc_clip_core u_core (
        .cmd    (cmd_reg),
        .bounds (bounds),
        .rect   (rect_next)
    );

    // result register strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= cmd_valid_reg;
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (cmd_valid_reg)
            rect_reg <= rect_next;
    end

    assign done       = done_reg;
    assign valid_res  = rect_reg.ok;
    assign out_src_x  = rect_reg.src_x;
    assign out_src_y  = rect_reg.src_y;
    assign out_dest_x = rect_reg.dst_x;
    assign out_dest_y = rect_reg.dst_y;
    assign out_width  = rect_reg.width;
    assign out_height = rect_reg.height;

    // every accepted request gives a result once it has passed the input and result registers
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> ##1 done)
        else $error("accepted request gave no result");

    // no result without a request in flight
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(cmd_valid_reg))
        else $error("result without request");

    // an empty rectangle reports all fields zero
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !valid_res) |-> (out_src_x == '0 && out_src_y == '0 &&
            out_dest_x == '0 && out_dest_y == '0 && out_width == '0 && out_height == '0))
        else $error("empty result with non-zero fields");

    // a valid rectangle has a non-zero size
    a_valid_size: assert property (@(posedge clk) disable iff (!rst_n)
        (done && valid_res) |-> (out_width != '0 && out_height != '0))
        else $error("valid result with zero size");

endmodule

// File: dv/brc_result_checker.sv
// brc_result_checker: watches the command, configuration and result channels of the clipper
// keeps its own copy of the registers, predicts each clipped rectangle and compares
// depends on brc_pkg for the command and result types and the register indexes

module brc_result_checker
    import brc_pkg::*;
#(
    parameter int MAX_DIM = 1024
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic                    busy,
    input  logic                    whole_source,
    input  logic signed [IN_W-1:0]  rect_x,
    input  logic signed [IN_W-1:0]  rect_y,
    input  logic signed [IN_W-1:0]  rect_w,
    input  logic signed [IN_W-1:0]  rect_h,
    input  logic signed [IN_W-1:0]  dest_x,
    input  logic signed [IN_W-1:0]  dest_y,
    input  logic                    cfg_valid,
    input  logic                    cfg_ready,
    input  logic [IDX_W-1:0]        cfg_index,
    input  logic [REG_W-1:0]        cfg_data,
    input  logic                    done,
    input  logic                    valid_res,
    input  logic [POS_W-1:0]        out_src_x,
    input  logic [POS_W-1:0]        out_src_y,
    input  logic [POS_W-1:0]        out_dest_x,
    input  logic [POS_W-1:0]        out_dest_y,
    input  logic [LEN_W-1:0]        out_width,
    input  logic [LEN_W-1:0]        out_height,
    output int                      fail_count,
    output int                      outstanding
);

    timeunit 1ns;
    timeprecision 1ps;

    // shadow copy of the six clip and surface registers
    typedef struct packed {
        logic [REG_W-1:0] clip_left;
        logic [REG_W-1:0] clip_top;
        logic [REG_W-1:0] clip_width;
        logic [REG_W-1:0] clip_height;
        logic [REG_W-1:0] source_width;
        logic [REG_W-1:0] source_height;
    } clip_settings_t;

    localparam clip_settings_t RESET_SETTINGS = '{
        clip_left: 11'd0, clip_top: 11'd0, clip_width: 11'd1024,
        clip_height: 11'd1024, source_width: 11'd1024, source_height: 11'd1024
    };

    clip_settings_t settings;
    rect_t          pending_rects[$];
    rect_t          want_rect;
    rect_t          got_rect;
    cmd_t           seen_cmd;
    int             err_count;

    function automatic int sat_dim(input logic [REG_W-1:0] v);
        return (int'(v) > MAX_DIM) ? MAX_DIM : int'(v);
    endfunction

    // source trim first, then destination clip trim with matching source shifts
    function automatic rect_t clip_blit(input cmd_t c, input clip_settings_t s);
        int    sw, sh, cl, ct, cr, cb;
        int    rx, ry, rw, rh, dx, dy, x2, y2;
        rect_t r;
        sw = sat_dim(s.source_width);
        sh = sat_dim(s.source_height);
        cl = sat_dim(s.clip_left);
        ct = sat_dim(s.clip_top);
        cr = cl + int'(s.clip_width);
        cb = ct + int'(s.clip_height);
        if (cr > MAX_DIM) cr = MAX_DIM;
        if (cb > MAX_DIM) cb = MAX_DIM;
        r = '0;
        if (c.whole_source)
        begin
            rx = 0;
            ry = 0;
            rw = sw;
            rh = sh;
        end
        else
        begin
            rx = int'(c.rect_x);
            ry = int'(c.rect_y);
            rw = int'(c.rect_w);
            rh = int'(c.rect_h);
        end
        dx = int'(c.dest_x);
        dy = int'(c.dest_y);

        // trim to the source surface
        if (rx < 0)
        begin
            rw = rw + rx;
            dx = dx - rx;
            rx = 0;
        end
        if (ry < 0)
        begin
            rh = rh + ry;
            dy = dy - ry;
            ry = 0;
        end
        if (rx + rw > sw) rw = sw - rx;
        if (ry + rh > sh) rh = sh - ry;
        if (rw <= 0 || rh <= 0) return r;

        // trim to the destination clip rectangle
        x2 = dx + rw;
        y2 = dy + rh;
        if (dx < cl)
        begin
            rx = rx + (cl - dx);
            rw = rw - (cl - dx);
            dx = cl;
        end
        if (dy < ct)
        begin
            ry = ry + (ct - dy);
            rh = rh - (ct - dy);
            dy = ct;
        end
        if (x2 > cr) rw = rw - (x2 - cr);
        if (y2 > cb) rh = rh - (y2 - cb);
        if (rw <= 0 || rh <= 0) return r;

        r.ok     = 1'b1;
        r.src_x  = rx[POS_W-1:0];
        r.src_y  = ry[POS_W-1:0];
        r.dst_x  = dx[POS_W-1:0];
        r.dst_y  = dy[POS_W-1:0];
        r.width  = rw[LEN_W-1:0];
        r.height = rh[LEN_W-1:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settings = RESET_SETTINGS;
            pending_rects.delete();
            err_count = 0;
        end
        else
        begin
            // compare each result with the oldest prediction
            if (done)
            begin
                got_rect = '{ok: valid_res, src_x: out_src_x, src_y: out_src_y,
                             dst_x: out_dest_x, dst_y: out_dest_y,
                             width: out_width, height: out_height};
                if (pending_rects.size() == 0)
                begin
                    if (err_count < 10)
                        $display({"%0t: result with no request waiting: ",
                                  "ok=%0d src=(%0d,%0d) dst=(%0d,%0d) size=%0dx%0d"},
                                 $realtime, got_rect.ok, got_rect.src_x, got_rect.src_y,
                                 got_rect.dst_x, got_rect.dst_y, got_rect.width,
                                 got_rect.height);
                    err_count++;
                end
                else
                begin
                    want_rect = pending_rects.pop_front();
                    if (got_rect !== want_rect)
                    begin
                        if (err_count < 10)
                        begin
                            $display({"%0t: mismatch expected ok=%0d src=(%0d,%0d) ",
                                      "dst=(%0d,%0d) size=%0dx%0d"},
                                     $realtime, want_rect.ok, want_rect.src_x, want_rect.src_y,
                                     want_rect.dst_x, want_rect.dst_y, want_rect.width,
                                     want_rect.height);
                            $display({"%0t:          actual ok=%0d src=(%0d,%0d) ",
                                      "dst=(%0d,%0d) size=%0dx%0d"},
                                     $realtime, got_rect.ok, got_rect.src_x, got_rect.src_y,
                                     got_rect.dst_x, got_rect.dst_y, got_rect.width,
                                     got_rect.height);
                        end
                        err_count++;
                    end
                end
            end

            // predict each accepted request with the settings in force
            if (start && !busy)
            begin
                seen_cmd = '{whole_source: whole_source, rect_x: rect_x, rect_y: rect_y,
                             rect_w: rect_w, rect_h: rect_h, dest_x: dest_x, dest_y: dest_y};
                pending_rects.push_back(clip_blit(seen_cmd, settings));
            end

            // follow register writes
            if (cfg_valid && cfg_ready)
            begin
                case (reg_idx_t'(cfg_index))
                    IDX_CLIP_LEFT:     settings.clip_left     = cfg_data;
                    IDX_CLIP_TOP:      settings.clip_top      = cfg_data;
                    IDX_CLIP_WIDTH:    settings.clip_width    = cfg_data;
                    IDX_CLIP_HEIGHT:   settings.clip_height   = cfg_data;
                    IDX_SOURCE_WIDTH:  settings.source_width  = cfg_data;
                    IDX_SOURCE_HEIGHT: settings.source_height = cfg_data;
                    default: ;
                endcase
            end
        end
        fail_count  <= err_count;
        outstanding <= pending_rects.size();
    end

endmodule

// File: dv/blit_rectangle_clipper_test.sv
// blit_rectangle_clipper_test: stimulus, watchdog and verdict for the blit rectangle clipper
// depends on brc_pkg, blit_rectangle_clipper and brc_result_checker

module blit_rectangle_clipper_test
    import brc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT   = 1000;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 62;

    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   start        = 1'b0;
    logic                   whole_source = 1'b0;
    logic signed [IN_W-1:0] rect_x       = '0;
    logic signed [IN_W-1:0] rect_y       = '0;
    logic signed [IN_W-1:0] rect_w       = '0;
    logic signed [IN_W-1:0] rect_h       = '0;
    logic signed [IN_W-1:0] dest_x       = '0;
    logic signed [IN_W-1:0] dest_y       = '0;
    logic                   cfg_valid    = 1'b0;
    logic [IDX_W-1:0]       cfg_index    = IDX_CLIP_LEFT;
    logic [REG_W-1:0]       cfg_data     = '0;

    logic                   busy;
    logic                   cfg_ready;
    logic                   done;
    logic                   valid_res;
    logic [POS_W-1:0]       out_src_x;
    logic [POS_W-1:0]       out_src_y;
    logic [POS_W-1:0]       out_dest_x;
    logic [POS_W-1:0]       out_dest_y;
    logic [LEN_W-1:0]       out_width;
    logic [LEN_W-1:0]       out_height;

    int                     fail_count;
    int                     outstanding;
    int                     idle_cycles = 0;
    int                     max_gap     = 15;

    always #1 clk = ~clk;

    blit_rectangle_clipper dut (
        .clk(clk), .rst_n(rst_n),
        .start(start), .busy(busy),
        .whole_source(whole_source),
        .rect_x(rect_x), .rect_y(rect_y), .rect_w(rect_w), .rect_h(rect_h),
        .dest_x(dest_x), .dest_y(dest_y),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .done(done), .valid_res(valid_res),
        .out_src_x(out_src_x), .out_src_y(out_src_y),
        .out_dest_x(out_dest_x), .out_dest_y(out_dest_y),
        .out_width(out_width), .out_height(out_height)
    );

    brc_result_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .start(start), .busy(busy),
        .whole_source(whole_source),
        .rect_x(rect_x), .rect_y(rect_y), .rect_w(rect_w), .rect_h(rect_h),
        .dest_x(dest_x), .dest_y(dest_y),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .done(done), .valid_res(valid_res),
        .out_src_x(out_src_x), .out_src_y(out_src_y),
        .out_dest_x(out_dest_x), .out_dest_y(out_dest_y),
        .out_width(out_width), .out_height(out_height),
        .fail_count(fail_count), .outstanding(outstanding)
    );

    // watchdog: cycles without any request, register write or result
    always @(posedge clk)
    begin
        if ((start && !busy) || (cfg_valid && cfg_ready) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        while (idle_cycles < IDLE_LIMIT)
            @(posedge clk);
        $display("Verification failed");
        $finish;
    end

    // one command request, after a random gap
    task automatic issue_cmd(input cmd_t c);
        bit taken;
        int gap;
        gap = $urandom_range(0, max_gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start        <= 1'b1;
        whole_source <= c.whole_source;
        rect_x       <= c.rect_x;
        rect_y       <= c.rect_y;
        rect_w       <= c.rect_w;
        rect_h       <= c.rect_h;
        dest_x       <= c.dest_x;
        dest_y       <= c.dest_y;
        do
        begin
            @(negedge clk);
            taken = !busy;
            @(posedge clk);
        end while (!taken);
    endtask

    task automatic directed_cmd(input int ws, input int x, input int y, input int w,
                                input int h, input int dx, input int dy);
        cmd_t c;
        c.whole_source = (ws != 0);
        c.rect_x = x[IN_W-1:0];
        c.rect_y = y[IN_W-1:0];
        c.rect_w = w[IN_W-1:0];
        c.rect_h = h[IN_W-1:0];
        c.dest_x = dx[IN_W-1:0];
        c.dest_y = dy[IN_W-1:0];
        issue_cmd(c);
    endtask

    // stop issuing and wait until every predicted result has arrived
    task automatic drain;
        start <= 1'b0;
        do
            @(negedge clk);
        while (outstanding != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [REG_W-1:0] val);
        bit taken;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
        begin
            @(negedge clk);
            taken = cfg_ready;
            @(posedge clk);
        end while (!taken);
    endtask

    // full register set, written only with the block idle
    task automatic apply_settings(input logic [REG_W-1:0] cl, input logic [REG_W-1:0] ct,
                                  input logic [REG_W-1:0] cw, input logic [REG_W-1:0] ch,
                                  input logic [REG_W-1:0] sw, input logic [REG_W-1:0] sh);
        drain();
        write_reg(IDX_CLIP_LEFT, cl);
        write_reg(IDX_CLIP_TOP, ct);
        write_reg(IDX_CLIP_WIDTH, cw);
        write_reg(IDX_CLIP_HEIGHT, ch);
        write_reg(IDX_SOURCE_WIDTH, sw);
        write_reg(IDX_SOURCE_HEIGHT, sh);
        cfg_valid <= 1'b0;
    endtask

    // register value: mostly plausible, now and then an extreme
    function automatic logic [REG_W-1:0] pick_reg(input int typ_hi);
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return 11'd1024;
            2:       return 11'd2047;
            3:       return REG_W'($urandom_range(0, 2047));
            default: return REG_W'($urandom_range(1, typ_hi));
        endcase
    endfunction

    // coordinate: mostly near the surface, a quarter over the full signed range
    function automatic logic signed [IN_W-1:0] pick_coord(input int lo, input int hi);
        int v;
        if ($urandom_range(0, 3) == 0)
            return IN_W'($urandom);
        v = int'($urandom_range(0, hi - lo)) + lo;
        return v[IN_W-1:0];
    endfunction

    initial
    begin
        cmd_t rc;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset settings, whole source, empty sizes, field extremes
        directed_cmd(1, 0, 0, 0, 0, 0, 0);
        directed_cmd(1, 2047, -2048, -2048, 2047, -5, -7);
        directed_cmd(0, 0, 0, 0, 10, 0, 0);
        directed_cmd(0, 0, 0, 10, -1, 0, 0);
        directed_cmd(0, -2048, -2048, 2047, 2047, 2047, 2047);
        directed_cmd(0, -10, -20, 100, 100, 5, 5);
        directed_cmd(0, 1000, 1000, 2047, 2047, 0, 0);
        directed_cmd(0, 0, 0, 2047, 2047, -2048, -2048);
        directed_cmd(0, 0, 0, 100, 100, -50, -60);
        directed_cmd(0, 0, 0, 100, 100, 1000, 1010);
        directed_cmd(0, 2047, 2047, 1, 1, 0, 0);
        directed_cmd(0, 1023, 1023, 1, 1, 1023, 1023);
        directed_cmd(0, 0, 0, 1, 1, 1024, 0);
        directed_cmd(0, -1, -1, -2048, -2048, -1, -1);

        // empty source surface
        apply_settings(11'd0, 11'd0, 11'd1024, 11'd1024, 11'd0, 11'd0);
        directed_cmd(1, 0, 0, 0, 0, 0, 0);
        directed_cmd(0, 0, 0, 10, 10, 0, 0);

        // oversized source and clip edges past the surface
        apply_settings(11'd2047, 11'd2047, 11'd2047, 11'd2047, 11'd2047, 11'd2047);
        directed_cmd(1, 0, 0, 0, 0, 0, 0);
        apply_settings(11'd1000, 11'd900, 11'd2047, 11'd2047, 11'd2047, 11'd2047);
        directed_cmd(1, 0, 0, 0, 0, -3, 0);
        directed_cmd(0, 5, 6, 200, 300, 950, 850);

        // zero-area clip, then a one-pixel source
        apply_settings(11'd10, 11'd10, 11'd0, 11'd50, 11'd1024, 11'd1024);
        directed_cmd(1, 0, 0, 0, 0, 0, 0);
        apply_settings(11'd1, 11'd2, 11'd1023, 11'd1022, 11'd1, 11'd1);
        directed_cmd(1, 0, 0, 0, 0, 1, 2);
        directed_cmd(0, 0, 0, 1, 1, 1023, 1023);

        // random phases, every other one with no idling
        for (int p = 0; p < PHASES; p++)
        begin
            apply_settings(pick_reg(300), pick_reg(300), pick_reg(1100),
                           pick_reg(1100), pick_reg(1100), pick_reg(1100));
            max_gap = (p % 2 == 1) ? 0 : 15;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                rc.whole_source = ($urandom_range(0, 4) == 0);
                rc.rect_x = pick_coord(-100, 1100);
                rc.rect_y = pick_coord(-100, 1100);
                rc.rect_w = pick_coord(-20, 1100);
                rc.rect_h = pick_coord(-20, 1100);
                rc.dest_x = pick_coord(-200, 1100);
                rc.dest_y = pick_coord(-200, 1100);
                issue_cmd(rc);
                // occasional hold-off until the pipeline is empty
                if ($urandom_range(0, 49) == 0)
                    drain();
            end
        end

        drain();
        repeat (8) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
